// ----- rtl/dsvx_pkg.sv -----
package dsvx_pkg;

    localparam int SAMPLE_DEPTH = 16384;
    localparam int FADE_LENGTH  = 100;

    localparam int ADDR_W     = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W      = 15;
    localparam int POS_W      = 15;
    localparam int FSTEP_W    = $clog2(FADE_LENGTH + 1);
    localparam int SMP_W      = 16;
    localparam int OP_W       = 2;
    localparam int SADDR_W    = 14;
    localparam int PAN_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int MIX_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int UNITY      = 65536;

    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_TRIG = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX    = 2'd3;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_HOLD = 3'd0;
    localparam logic [KIND_W-1:0] K_ZERO = 3'd1;
    localparam logic [KIND_W-1:0] K_PLAY = 3'd2;
    localparam logic [KIND_W-1:0] K_FADE = 3'd3;
    localparam logic [KIND_W-1:0] K_LOAD = 3'd4;

    // crossfade: weighted sum with offset, then divide by FADE_LENGTH via reciprocal
    localparam longint NUM_MAX   = longint'(65535) * FADE_LENGTH + FADE_LENGTH / 2;
    localparam int     NUM_W     = $clog2(NUM_MAX + 1);
    localparam int     FADE_BIAS = 32768 * FADE_LENGTH + FADE_LENGTH / 2;
    localparam int     DIV_SH    = NUM_W + $clog2(FADE_LENGTH);
    localparam int     DIV_M_W   = NUM_W + 1;
    localparam longint DIV_M_L   = ((longint'(1) << DIV_SH) + FADE_LENGTH - 1) / FADE_LENGTH;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_L);
    localparam int     QP_W      = NUM_W + DIV_M_W;
    localparam int     PA_W      = SMP_W + FSTEP_W + 1;
    localparam int     ACC_W     = ((PA_W > NUM_W) ? PA_W : NUM_W) + 2;

    // output scaling: sample * pan * gain * mix, Q1.15 result
    localparam int PG_W   = 32;
    localparam int COEF_W = 48;
    localparam int COEF_H = COEF_W / 2;
    localparam int SCL_SH = 46;
    localparam int PH_W   = SMP_W + COEF_H;
    localparam int FULL_W = SMP_W + COEF_W;
    localparam int RND_W  = FULL_W - SCL_SH;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [PAN_W-1:0]  pan;
        logic [GAIN_W-1:0] gain;
        logic [MIX_W-1:0]  mix;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               rd_zero;
        logic [ADDR_W-1:0]  addr_a;
        logic [ADDR_W-1:0]  addr_b;
        logic [FSTEP_W-1:0] fade_k;
        logic [SMP_W-1:0]   wdata;
        logic               playing;
        logic               started;
        logic               finished;
    } t_cmd;

endpackage

// ----- rtl/dsvx_if.sv -----
interface dsvx_in_if import dsvx_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic [SADDR_W-1:0]        sample_addr;
    logic signed [SMP_W-1:0]   sample_value;

    modport source (output valid, opcode, sample_addr, sample_value, input ready);
    modport sink   (input valid, opcode, sample_addr, sample_value, output ready);
endinterface

interface dsvx_out_if import dsvx_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SMP_W-1:0]   voice_sample;
    logic signed [SMP_W-1:0]   dry_left;
    logic signed [SMP_W-1:0]   dry_right;
    logic signed [SMP_W-1:0]   comp_left;
    logic signed [SMP_W-1:0]   comp_right;
    logic                      playing;
    logic                      started;
    logic                      finished;

    modport source (output valid, voice_sample, dry_left, dry_right, comp_left, comp_right,
                    playing, started, finished, input ready);
    modport sink   (input valid, voice_sample, dry_left, dry_right, comp_left, comp_right,
                    playing, started, finished, output ready);
endinterface

interface dsvx_cfg_if import dsvx_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dsvx_ram.sv -----
module dsvx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dsvx_front.sv -----
module dsvx_front import dsvx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dsvx_in_if.sink          i_item,
    input  logic [LEN_W-1:0] i_length,
    input  logic             i_q_ready,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic               r_playing, n_playing;
    logic               r_fading, n_fading;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [FSTEP_W-1:0] r_step, n_step;

    logic [LEN_W-1:0]   eff;
    logic [LEN_W-1:0]   last_idx;
    logic               len_zero;
    logic [POS_W:0]     pos_x;
    logic [POS_W:0]     pos_inc;
    logic [POS_W:0]     prev;
    logic [FSTEP_W-1:0] step_inc;
    t_cmd               cmd;

    function automatic logic [ADDR_W-1:0] clamp_idx(input logic [POS_W:0] idx,
                                                    input logic [LEN_W-1:0] lst);
        logic [POS_W:0] lst_x;
        lst_x = (POS_W + 1)'(lst);
        if (idx > lst_x) begin
            return ADDR_W'(lst);
        end
        return ADDR_W'(idx);
    endfunction

    assign i_item.ready = i_q_ready;
    assign o_push       = i_item.valid && i_q_ready;
    assign o_cmd        = cmd;

    always_comb begin
        eff       = (int'(i_length) > SAMPLE_DEPTH) ? LEN_W'(SAMPLE_DEPTH) : i_length;
        len_zero  = (eff == '0);
        last_idx  = eff - LEN_W'(1);
        pos_x     = {1'b0, r_pos};
        pos_inc   = pos_x + (POS_W + 1)'(1);
        prev      = pos_x + (POS_W + 1)'(r_step);
        step_inc  = r_step + FSTEP_W'(1);

        n_playing = r_playing;
        n_fading  = r_fading;
        n_pos     = r_pos;
        n_step    = r_step;

        cmd.kind     = K_HOLD;
        cmd.rd_zero  = len_zero;
        cmd.addr_a   = clamp_idx(pos_x, last_idx);
        cmd.addr_b   = clamp_idx((POS_W + 1)'(r_step), last_idx);
        cmd.fade_k   = r_step;
        cmd.wdata    = i_item.sample_value;
        cmd.started  = 1'b0;
        cmd.finished = 1'b0;

        case (i_item.opcode)
            OP_TICK: begin
                if (r_playing) begin
                    if (!r_fading) begin
                        cmd.kind = K_PLAY;
                        n_pos    = POS_W'(pos_inc);
                        if (pos_inc >= (POS_W + 1)'(eff)) begin
                            n_playing    = 1'b0;
                            cmd.finished = 1'b1;
                        end
                    end else begin
                        cmd.kind   = K_FADE;
                        cmd.addr_a = clamp_idx(prev, last_idx);
                        n_step     = step_inc;
                        if (int'(step_inc) >= FADE_LENGTH) begin
                            n_pos    = POS_W'(step_inc);
                            n_fading = 1'b0;
                        end
                    end
                end
            end
            OP_TRIG: begin
                if (!len_zero) begin
                    if (!r_playing) begin
                        cmd.kind    = K_ZERO;
                        cmd.started = 1'b1;
                        n_playing   = 1'b1;
                        n_fading    = 1'b0;
                        n_pos       = '0;
                    end else begin
                        n_fading = 1'b1;
                        n_step   = '0;
                    end
                end
            end
            OP_LOAD: begin
                if (int'(i_item.sample_addr) < SAMPLE_DEPTH) begin
                    cmd.kind   = K_LOAD;
                    cmd.addr_a = ADDR_W'(i_item.sample_addr);
                end
            end
            default: begin
            end
        endcase

        cmd.playing = n_playing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_fading  <= 1'b0;
            r_pos     <= '0;
            r_step    <= '0;
        end else if (o_push) begin
            r_playing <= n_playing;
            r_fading  <= n_fading;
            r_pos     <= n_pos;
            r_step    <= n_step;
        end
    end

`ifndef ASSERT_OFF
    a_fade_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fading |-> r_playing)
        else $error("fade active while voice idle");
`endif

endmodule

// ----- rtl/dsvx_queue.sv -----
module dsvx_queue import dsvx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_PW-1:0]   r_wr;
    logic [Q_PW-1:0]   r_rd;
    logic [Q_PW:0]     r_count;

    function automatic logic [Q_PW-1:0] ptr_next(input logic [Q_PW-1:0] p);
        if (p == Q_PW'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + Q_PW'(1);
    endfunction

    assign o_ready = (r_count != (Q_PW + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_PW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (Q_PW + 1)'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PW + 1)'(Q_DEPTH))
        else $error("queue count above depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/dsvx_back.sv -----
module dsvx_back import dsvx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_q_valid,
    input  t_cmd     i_q_cmd,
    output logic     o_pop,
    dsvx_out_if.source o_result
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RDA  = 3'd1;
    localparam logic [2:0] B_RDB  = 3'd2;
    localparam logic [2:0] B_DIV  = 3'd3;
    localparam logic [2:0] B_SMP  = 3'd4;
    localparam logic [2:0] B_SCL  = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    logic [2:0]               r_state, n_state;
    t_cmd                     r_cmd;
    logic signed [SMP_W-1:0]  r_wa;
    logic signed [PA_W-1:0]   r_pa, r_pb;
    logic [QP_W-1:0]          r_qprod;
    logic [SMP_W-1:0]         r_last;
    logic                     r_neg;
    logic [PG_W-1:0]          r_pg [2];
    logic [COEF_W-1:0]        r_coef [4];
    logic [PH_W-1:0]          r_plo [4];
    logic [PH_W-1:0]          r_phi [4];

    logic                     r_out_valid;
    logic [SMP_W-1:0]         r_o_voice;
    logic [SMP_W-1:0]         r_o_lane [4];
    logic                     r_o_playing, r_o_started, r_o_finished;

    logic                     ram_we, ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [SMP_W-1:0]         ram_rdata;
    logic signed [SMP_W-1:0]  word_rd;

    logic [PAN_W-1:0]         pl, pr;
    logic [MIX_W-1:0]         mc, md;
    logic [PAN_W+GAIN_W-1:0]  pg_l, pg_r;
    logic [FSTEP_W-1:0]       wgt_a;
    logic signed [PA_W-1:0]   wa_x, wb_x, ka_x, kb_x;
    logic signed [ACC_W-1:0]  num_s;
    logic [NUM_W-1:0]         num_u;
    logic [SMP_W-1:0]         fade_q;
    logic [SMP_W-1:0]         mag;
    logic                     out_load;

    function automatic logic [SMP_W-1:0] sat_lane(input logic [PH_W-1:0] lo,
                                                  input logic [PH_W-1:0] hi,
                                                  input logic neg);
        logic [FULL_W-1:0] full;
        logic [RND_W-1:0]  r;
        full = FULL_W'(lo) + (FULL_W'(hi) << COEF_H) + (FULL_W'(1) << (SCL_SH - 1));
        r = full[FULL_W-1:SCL_SH];
        if (neg) begin
            if (r > RND_W'(32768)) begin
                return SMP_W'(16'h8000);
            end
            return SMP_W'(RND_W'(0) - r);
        end
        if (r > RND_W'(32767)) begin
            return SMP_W'(16'h7FFF);
        end
        return SMP_W'(r);
    endfunction

    dsvx_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_cmd.addr_a),
        .i_wdata (i_q_cmd.wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // coefficient pipeline, follows the config registers
    always_comb begin
        pl   = (int'(i_cfg.pan) > UNITY) ? PAN_W'(UNITY) : i_cfg.pan;
        pr   = PAN_W'(UNITY) - pl;
        mc   = (int'(i_cfg.mix) > UNITY) ? MIX_W'(UNITY) : i_cfg.mix;
        md   = MIX_W'(UNITY) - mc;
        pg_l = (PAN_W + GAIN_W)'(pl) * (PAN_W + GAIN_W)'(i_cfg.gain);
        pg_r = (PAN_W + GAIN_W)'(pr) * (PAN_W + GAIN_W)'(i_cfg.gain);
    end

    always_ff @(posedge i_clk) begin
        r_pg[0]   <= pg_l[PG_W-1:0];
        r_pg[1]   <= pg_r[PG_W-1:0];
        r_coef[0] <= COEF_W'(COEF_W'(r_pg[0]) * COEF_W'(md));
        r_coef[1] <= COEF_W'(COEF_W'(r_pg[1]) * COEF_W'(md));
        r_coef[2] <= COEF_W'(COEF_W'(r_pg[0]) * COEF_W'(mc));
        r_coef[3] <= COEF_W'(COEF_W'(r_pg[1]) * COEF_W'(mc));
    end

    always_comb begin
        o_pop     = (r_state == B_IDLE) && i_q_valid;
        ram_we    = o_pop && (i_q_cmd.kind == K_LOAD);
        ram_re    = o_pop || (r_state == B_RDA);
        ram_raddr = (r_state == B_RDA) ? r_cmd.addr_b : i_q_cmd.addr_a;
        word_rd   = r_cmd.rd_zero ? '0 : $signed(ram_rdata);

        wgt_a = FSTEP_W'(FADE_LENGTH) - r_cmd.fade_k;
        wa_x  = PA_W'(r_wa);
        wb_x  = PA_W'(word_rd);
        ka_x  = PA_W'({1'b0, wgt_a});
        kb_x  = PA_W'({1'b0, r_cmd.fade_k});

        num_s  = ACC_W'(r_pa) + ACC_W'(r_pb) + ACC_W'(FADE_BIAS);
        num_u  = num_s[NUM_W-1:0];
        fade_q = r_qprod[DIV_SH +: SMP_W] - SMP_W'(16'h8000);

        mag = r_last[SMP_W-1] ? (SMP_W'(~r_last) + SMP_W'(1)) : r_last;

        out_load = (r_state == B_OUT) && (!r_out_valid || o_result.ready);

        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.kind == K_PLAY || i_q_cmd.kind == K_FADE) begin
                        n_state = B_RDA;
                    end else begin
                        n_state = B_SMP;
                    end
                end
            end
            B_RDA:   n_state = (r_cmd.kind == K_FADE) ? B_RDB : B_SMP;
            B_RDB:   n_state = B_DIV;
            B_DIV:   n_state = B_SMP;
            B_SMP:   n_state = B_SCL;
            B_SCL:   n_state = B_OUT;
            B_OUT:   n_state = out_load ? B_IDLE : B_OUT;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == B_RDA) begin
            r_wa <= word_rd;
        end
        if (r_state == B_RDB) begin
            r_pa <= wa_x * ka_x;
            r_pb <= wb_x * kb_x;
        end
        if (r_state == B_DIV) begin
            r_qprod <= QP_W'(num_u) * QP_W'(DIV_M);
        end
        if (r_state == B_SCL) begin
            r_neg <= r_last[SMP_W-1];
            for (int i = 0; i < 4; i++) begin
                r_plo[i] <= PH_W'(mag) * PH_W'(r_coef[i][COEF_H-1:0]);
                r_phi[i] <= PH_W'(mag) * PH_W'(r_coef[i][COEF_W-1:COEF_H]);
            end
        end
        if (out_load) begin
            r_o_voice    <= r_last;
            r_o_playing  <= r_cmd.playing;
            r_o_started  <= r_cmd.started;
            r_o_finished <= r_cmd.finished;
            for (int i = 0; i < 4; i++) begin
                r_o_lane[i] <= sat_lane(r_plo[i], r_phi[i], r_neg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_SMP) begin
                case (r_cmd.kind)
                    K_PLAY:  r_last <= r_wa;
                    K_FADE:  r_last <= fade_q;
                    K_ZERO:  r_last <= '0;
                    default: r_last <= r_last;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.voice_sample = r_o_voice;
    assign o_result.dry_left     = r_o_lane[0];
    assign o_result.dry_right    = r_o_lane[1];
    assign o_result.comp_left    = r_o_lane[2];
    assign o_result.comp_right   = r_o_lane[3];
    assign o_result.playing      = r_o_playing;
    assign o_result.started      = r_o_started;
    assign o_result.finished     = r_o_finished;

`ifndef ASSERT_OFF
    a_rdb_is_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RDB) |-> (r_cmd.kind == K_FADE))
        else $error("second read for a non-fade command");
    a_fade_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SMP && r_cmd.kind == K_FADE) |-> ($past(r_state) == B_DIV))
        else $error("fade sample taken before the divide");
`endif

endmodule

// ----- rtl/drum_sample_voice_crossfade_top.sv -----
// Channel   Dir  Port      Transfer
// item      in   i_item    valid & ready; opcode, sample_addr, sample_value
// result    out  o_result  valid & ready; voice_sample, dry/comp left/right, flags
// config    in   i_cfg     valid & ready (ready tied high); index, data
//
// The back end takes an item through sample, scale and output (hold, start, load);
// a playback tick adds a read, and a crossfade tick adds two reads and a divide; the
// single sample RAM read port makes the two reads come in turn. The front end pushes
// an accepted item into the two-entry queue in the same cycle while it has room. A
// result waits in the output register; the back end stalls there only while that
// register is full and not taken. Reset is synchronous; the sample RAM is not cleared.
module drum_sample_voice_crossfade_top import dsvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsvx_in_if.sink     i_item,
    dsvx_out_if.source  o_result,
    dsvx_cfg_if.sink    i_cfg
);

    t_cfg r_cfg;
    logic q_ready, q_valid, q_push, q_pop;
    t_cmd q_in_cmd, q_out_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.length <= '0;
            r_cfg.pan    <= PAN_W'(32768);
            r_cfg.gain   <= GAIN_W'(16384);
            r_cfg.mix    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LENGTH: r_cfg.length <= i_cfg.data[LEN_W-1:0];
                REG_PAN:    r_cfg.pan    <= i_cfg.data[PAN_W-1:0];
                REG_GAIN:   r_cfg.gain   <= i_cfg.data[GAIN_W-1:0];
                REG_MIX:    r_cfg.mix    <= i_cfg.data[MIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dsvx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_length  (r_cfg.length),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (q_in_cmd)
    );

    dsvx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd)
    );

    dsvx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_out_cmd),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

endmodule
